// ===== design/igru_pkg.sv =====
package igru_pkg;

	// field widths fixed by the interface
	localparam int DIM_W   = 13;
	localparam int POS_W   = 12;
	localparam int GRAY_W  = 8;
	localparam int BYTE_W  = 8;
	localparam int DEPTH_W = 2;
	localparam int CFG_IDX_W = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_CODE   = 2'd2;

	// request kinds
	localparam logic ACT_PALETTE = 1'b0;
	localparam logic ACT_DATA    = 1'b1;

	// depth codes
	localparam logic [DEPTH_W-1:0] DEPTH_1BPP = 2'd0;
	localparam logic [DEPTH_W-1:0] DEPTH_2BPP = 2'd1;
	localparam logic [DEPTH_W-1:0] DEPTH_4BPP = 2'd2;
	localparam logic [DEPTH_W-1:0] DEPTH_8BPP = 2'd3;

	typedef struct packed {
		logic              action;
		logic [BYTE_W-1:0] palette_index;
		logic [GRAY_W-1:0] palette_gray;
		logic [BYTE_W-1:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [GRAY_W-1:0] gray;
		logic [POS_W-1:0]  column;
		logic [POS_W-1:0]  row_from_top;
		logic              last;
		logic              end_of_image;
	} out_item_t;

	typedef enum logic {
		ST_IDLE,
		ST_SEND
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic pal_wr;
		logic pad_byte;
		logic start_byte;
		logic pix_adv;
		logic pix_end;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic pad;
		logic last;
	} dp_status_t;

endpackage

// ===== design/indexed_gray_row_unpacker.sv =====
// indexed gray row unpacker
//
// item channel (item_valid/item_ready/item): a request either loads one gray
// palette entry (action 0) or delivers one raw pixel byte (action 1), bytes
// in file order, bottom row first. pixel channel (pixel_valid/pixel_ready/
// pixel): one request per pixel, with gray value, column, row counted from the
// top, last pixel of the byte and last pixel of the image.
// cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): width, height and
// depth code; always ready. it is to be written by the user only while no
// byte is in progress; the block itself does not enforce this.
// the first pixel of a byte is offered in the cycle after the byte is taken.
// a byte yields n pixels (at most 8, fewer when the row ends inside the
// byte), and no new request is taken until its last pixel is accepted; the
// single palette read port is read once per pixel. palette loads and
// padding bytes yield no pixels.
//
// reset: counters at row 0 column 0, width 1, height 1, eight bits per pixel.
// palette contents are undefined until loaded and get no clearing pass.
// when the receiver stalls the pixel is held and no new item is taken.
module indexed_gray_row_unpacker
	import igru_pkg::*;
#(
	parameter int MAX_DIM         = 4096,
	parameter int PALETTE_ENTRIES = 256
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration writes
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0]     cfg_data,
	// palette loads and pixel bytes
	input  logic                 item_valid,
	output logic                 item_ready,
	input  in_item_t             item,
	// unpacked gray pixels
	output logic                 pixel_valid,
	input  logic                 pixel_ready,
	output out_item_t            pixel
);

	dp_cmd_t    cmd;
	dp_status_t status;

	// register writes complete at once
	assign cfg_ready = 1'b1;

	// sequencer: takes a request, then walks the pixels of a byte
	igru_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_action (item.action),
		.item_ready  (item_ready),
		.pixel_valid (pixel_valid),
		.pixel_ready (pixel_ready),
		.status      (status),
		.cmd         (cmd)
	);

	// counters, byte shifter, palette memory and config registers
	igru_dp #(
		.MAX_DIM         (MAX_DIM),
		.PALETTE_ENTRIES (PALETTE_ENTRIES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item      (item),
		.cmd       (cmd),
		.status    (status),
		.pixel     (pixel)
	);

endmodule

// ===== design/igru_ram.sv =====
module igru_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== design/igru_ctrl.sv =====
module igru_ctrl
	import igru_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	input  logic       item_action,
	output logic       item_ready,
	output logic       pixel_valid,
	input  logic       pixel_ready,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		item_ready  = 1'b0;
		pixel_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					if (item_action == ACT_PALETTE) begin
						cmd.pal_wr = 1'b1;
					end else if (status.pad) begin
						cmd.pad_byte = 1'b1;
					end else begin
						cmd.start_byte = 1'b1;
						state_d        = ST_SEND;
					end
				end
			end
			ST_SEND: begin
				pixel_valid = 1'b1;
				if (pixel_ready) begin
					if (status.last) begin
						cmd.pix_end = 1'b1;
						state_d     = ST_IDLE;
					end else begin
						cmd.pix_adv = 1'b1;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

`ifndef SYNTHESIS
	// at most one datapath operation per cycle
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.pal_wr, cmd.pad_byte, cmd.start_byte, cmd.pix_adv, cmd.pix_end}))
		else $error("igru_ctrl: more than one datapath command");

	// a byte that finishes returns the controller to taking requests
	a_end_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pix_end |=> state_q == ST_IDLE)
		else $error("igru_ctrl: not idle after last pixel of byte");
`endif

endmodule

// ===== design/igru_dp.sv =====
module igru_dp
	import igru_pkg::*;
#(
	parameter int MAX_DIM         = 4096,
	parameter int PALETTE_ENTRIES = 256
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0]     cfg_data,
	input  in_item_t             item,
	input  dp_cmd_t              cmd,
	output dp_status_t           status,
	output out_item_t            pixel
);

	localparam int PAL_AW = $clog2(PALETTE_ENTRIES);
	localparam int DIM_MAX_VAL = (1 << DIM_W) - 1;
	localparam logic [DIM_W-1:0] DIM_CAP =
		DIM_W'((MAX_DIM > DIM_MAX_VAL) ? DIM_MAX_VAL : MAX_DIM);
	localparam logic [BYTE_W:0] PAL_LIMIT = (BYTE_W+1)'(PALETTE_ENTRIES);

	logic [DIM_W-1:0]   width_q;
	logic [DIM_W-1:0]   height_q;
	logic [DEPTH_W-1:0] depth_q;
	logic [DIM_W-1:0]   col_q;
	logic [DIM_W-1:0]   row_q;
	logic [1:0]         phase_q;
	logic [2:0]         k_q;
	logic [BYTE_W-1:0]  byte_q;
	logic               zero_q;

	logic [DIM_W-1:0]   cfg_clamped;
	logic [BYTE_W-1:0]  byte_shl;
	logic [BYTE_W-1:0]  src_byte;
	logic [BYTE_W-1:0]  rd_idx;
	logic               rd_en;
	logic               wr_en;
	logic [GRAY_W-1:0]  rd_data;
	logic [DIM_W:0]     col_inc;
	logic [DIM_W:0]     row_inc;
	logic               row_end;
	logic               img_end;
	logic               k_last;
	logic [1:0]         phase_inc;
	logic [DIM_W-1:0]   from_top;

	// zero reads as one, anything past the cap reads as the cap
	always_comb begin
		if (cfg_data == '0) begin
			cfg_clamped = DIM_W'(1);
		end else if (cfg_data > DIM_CAP) begin
			cfg_clamped = DIM_CAP;
		end else begin
			cfg_clamped = cfg_data;
		end
	end

	// next pixel's bits brought to the top of the byte
	always_comb begin
		unique case (depth_q)
			DEPTH_1BPP: byte_shl = {byte_q[6:0], 1'b0};
			DEPTH_2BPP: byte_shl = {byte_q[5:0], 2'b0};
			DEPTH_4BPP: byte_shl = {byte_q[3:0], 4'b0};
			DEPTH_8BPP: byte_shl = '0;
			default:    byte_shl = '0;
		endcase
	end

	assign src_byte = cmd.start_byte ? item.data_byte : byte_shl;

	// index from the top bits of the byte
	always_comb begin
		unique case (depth_q)
			DEPTH_1BPP: rd_idx = {7'b0, src_byte[7]};
			DEPTH_2BPP: rd_idx = {6'b0, src_byte[7:6]};
			DEPTH_4BPP: rd_idx = {4'b0, src_byte[7:4]};
			DEPTH_8BPP: rd_idx = src_byte;
			default:    rd_idx = src_byte;
		endcase
	end

	assign rd_en = cmd.start_byte | cmd.pix_adv;
	assign wr_en = cmd.pal_wr && ({1'b0, item.palette_index} < PAL_LIMIT);

	igru_ram #(
		.WIDTH (GRAY_W),
		.DEPTH (PALETTE_ENTRIES)
	) u_palette (
		.clk   (clk),
		.we    (wr_en),
		.waddr (item.palette_index[PAL_AW-1:0]),
		.wdata (item.palette_gray),
		.re    (rd_en),
		.raddr (rd_idx[PAL_AW-1:0]),
		.rdata (rd_data)
	);

	assign col_inc   = {1'b0, col_q} + (DIM_W+1)'(1);
	assign row_inc   = {1'b0, row_q} + (DIM_W+1)'(1);
	assign row_end   = col_inc >= {1'b0, width_q};
	assign img_end   = row_inc >= {1'b0, height_q};
	assign k_last    = k_q == (3'd7 >> depth_q);
	assign phase_inc = phase_q + 2'd1;
	assign from_top  = height_q - DIM_W'(1) - row_q;

	assign status.pad  = col_q >= width_q;
	assign status.last = k_last | row_end;

	assign pixel.gray         = zero_q ? '0 : rd_data;
	assign pixel.column       = col_q[POS_W-1:0];
	assign pixel.row_from_top = from_top[POS_W-1:0];
	assign pixel.last         = k_last | row_end;
	assign pixel.end_of_image = row_end & img_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_W'(1);
			height_q <= DIM_W'(1);
			depth_q  <= DEPTH_8BPP;
			col_q    <= '0;
			row_q    <= '0;
			phase_q  <= '0;
			k_q      <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_IMAGE_WIDTH:  width_q  <= cfg_clamped;
					CFG_IMAGE_HEIGHT: height_q <= cfg_clamped;
					CFG_DEPTH_CODE:   depth_q  <= cfg_data[DEPTH_W-1:0];
					default: ;
				endcase
			end
			if (cmd.start_byte) begin
				k_q <= '0;
			end
			if (cmd.pix_adv) begin
				k_q   <= k_q + 3'd1;
				col_q <= col_inc[DIM_W-1:0];
			end
			if (cmd.pix_end || cmd.pad_byte) begin
				phase_q <= phase_inc;
				// row closes once its bytes reach a multiple of four
				if ((cmd.pad_byte || row_end) && phase_inc == 2'd0) begin
					col_q <= '0;
					row_q <= img_end ? '0 : row_inc[DIM_W-1:0];
				end else if (cmd.pix_end) begin
					col_q <= col_inc[DIM_W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_byte) begin
			byte_q <= item.data_byte;
		end else if (cmd.pix_adv) begin
			byte_q <= byte_shl;
		end
		if (rd_en) begin
			zero_q <= {1'b0, rd_idx} >= PAL_LIMIT;
		end
	end

`ifndef SYNTHESIS
	// pixels only leave while the row still has room
	a_col_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.pix_adv || cmd.pix_end) |-> col_q < width_q)
		else $error("igru_dp: pixel beyond row width");

	// a completed, aligned row restarts at column zero
	a_row_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.pix_end && row_end && phase_q == 2'd3) |=> col_q == '0)
		else $error("igru_dp: column not cleared at row start");

	// padding bytes leave the column alone unless they close the row
	a_pad_col: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.pad_byte && phase_q != 2'd3 && !cfg_we) |=> $stable(col_q))
		else $error("igru_dp: padding byte changed column");
`endif

endmodule

// ===== tb/gray_pixel_checker.sv =====
module gray_pixel_checker
	import igru_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0]     cfg_data,
	input  logic                 item_valid,
	input  logic                 item_ready,
	input  in_item_t             item,
	input  logic                 pixel_valid,
	input  logic                 pixel_ready,
	input  out_item_t            pixel,
	output int                   mismatches,
	output int                   backlog,
	output int                   pixels_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_DIM = 4096;

	logic [DIM_W-1:0]   width_reg;
	logic [DIM_W-1:0]   height_reg;
	logic [DEPTH_W-1:0] depth_reg;
	logic [GRAY_W-1:0]  gray_lut [256];
	int                 col_cnt;
	int                 row_cnt;
	logic [1:0]         byte_phase;
	out_item_t          pending_pixels [$];

	function automatic int clamp_dim(input int v);
		if (v == 0) begin
			return 1;
		end
		return (v > MAX_DIM) ? MAX_DIM : v;
	endfunction

	task automatic advance_row(input int height);
		col_cnt = 0;
		row_cnt = (row_cnt + 1 >= height) ? 0 : row_cnt + 1;
	endtask

	// expected pixels of one data byte, msb-first
	task automatic unpack_byte(input logic [BYTE_W-1:0] data);
		int        width;
		int        height;
		int        bpp;
		int        per_byte;
		int        idx;
		int        row_pos;
		int        n;
		logic      row_done;
		out_item_t px;
		out_item_t run_px [8];
		width    = clamp_dim(width_reg);
		height   = clamp_dim(height_reg);
		bpp      = 1 << depth_reg;
		per_byte = 8 / bpp;
		if (col_cnt >= width) begin
			// padding up to a four byte boundary
			byte_phase = byte_phase + 2'd1;
			if (byte_phase == 2'd0) begin
				advance_row(height);
			end
		end else begin
			n        = 0;
			row_done = 1'b0;
			for (int k = 0; k < per_byte && !row_done; k++) begin
				idx     = (data >> (8 - bpp * (k + 1))) & ((1 << bpp) - 1);
				row_pos = height - 1 - row_cnt;
				px.gray         = gray_lut[idx];
				px.column       = col_cnt[POS_W-1:0];
				px.row_from_top = row_pos[POS_W-1:0];
				px.last         = 1'b0;
				px.end_of_image = 1'b0;
				col_cnt++;
				if (col_cnt >= width) begin
					row_done        = 1'b1;
					px.end_of_image = (row_cnt + 1 >= height);
				end
				run_px[n] = px;
				n++;
			end
			run_px[n-1].last = 1'b1;
			for (int k = 0; k < n; k++) begin
				pending_pixels = {pending_pixels, run_px[k]};
			end
			byte_phase = byte_phase + 2'd1;
			if (row_done && byte_phase == 2'd0) begin
				advance_row(height);
			end
		end
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t ns: pixel %0d %s expected %0d actual %0d",
				$time, pixels_checked, name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		out_item_t want;
		if (!arst_n) begin
			width_reg  = 1;
			height_reg = 1;
			depth_reg  = DEPTH_8BPP;
			col_cnt    = 0;
			row_cnt    = 0;
			byte_phase = 2'd0;
			pending_pixels.delete();
			backlog    = 0;
		end else begin
			// outgoing pixel belongs to an older byte, so compare first
			if (pixel_valid && pixel_ready) begin
				if (pending_pixels.size() == 0) begin
					$display("%0t ns: unexpected pixel gray %0d column %0d row %0d, none expected",
						$time, pixel.gray, pixel.column, pixel.row_from_top);
					mismatches++;
				end else begin
					want = pending_pixels.pop_front();
					check_field("gray", want.gray, pixel.gray);
					check_field("column", want.column, pixel.column);
					check_field("row_from_top", want.row_from_top, pixel.row_from_top);
					check_field("last", want.last, pixel.last);
					check_field("end_of_image", want.end_of_image, pixel.end_of_image);
				end
				pixels_checked++;
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_IMAGE_WIDTH:  width_reg  = cfg_data;
					CFG_IMAGE_HEIGHT: height_reg = cfg_data;
					CFG_DEPTH_CODE:   depth_reg  = cfg_data[DEPTH_W-1:0];
					default: ;
				endcase
			end
			if (item_valid && item_ready) begin
				if (item.action == ACT_PALETTE) begin
					gray_lut[item.palette_index] = item.palette_gray;
				end else begin
					unpack_byte(item.data_byte);
				end
			end
			backlog = pending_pixels.size();
		end
	end

endmodule

// ===== tb/tb.sv =====
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import igru_pkg::*;

	// pacing of the run
	localparam int IDLE_PCT     = 12;   // chance per cycle that a side idles
	localparam int QUIET_CYCLES = 12;   // lets the block settle once no pixel is outstanding
	localparam int DRAIN_CYCLES = 24;
	localparam int STALL_LIMIT  = 2000; // cycles without any accepted request
	localparam int RANDOM_ITEMS = 160;

	// register index with no register behind it
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	logic                 clk         = 1'b0;
	logic                 arst_n      = 1'b0;
	logic                 cfg_valid   = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index   = '0;
	logic [DIM_W-1:0]     cfg_data    = '0;
	logic                 item_valid  = 1'b0;
	logic                 item_ready;
	in_item_t             item        = '0;
	logic                 pixel_valid;
	logic                 pixel_ready = 1'b0;
	out_item_t            pixel;

	// no idling on either side while set
	logic steady = 1'b0;

	int mismatches;
	int backlog;
	int pixels_checked;
	int palettes_sent;
	int bytes_sent;
	int cfg_writes;

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	indexed_gray_row_unpacker DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.pixel_valid(pixel_valid),
		.pixel_ready(pixel_ready),
		.pixel      (pixel)
	);

	// prediction and comparison live beside the block
	gray_pixel_checker u_pixel_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.item_valid    (item_valid),
		.item_ready    (item_ready),
		.item          (item),
		.pixel_valid   (pixel_valid),
		.pixel_ready   (pixel_ready),
		.pixel         (pixel),
		.mismatches    (mismatches),
		.backlog       (backlog),
		.pixels_checked(pixels_checked)
	);

	// receiver stalls at random except in the steady stretch
	always @(negedge clk) begin
		pixel_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
	end

	// one request on the item channel, called and returning at a falling edge
	task automatic send_item(input in_item_t req);
		while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item       <= req;
		item_valid <= 1'b1;
		@(posedge clk);
		while (!item_ready) begin
			@(posedge clk);
		end
		@(negedge clk);
	endtask

	// unused fields carry random noise
	task automatic send_palette(input int idx, input int gray);
		logic [31:0] noise;
		in_item_t    req;
		noise             = $urandom;
		req               = noise[$bits(in_item_t)-1:0];
		req.action        = ACT_PALETTE;
		req.palette_index = idx[BYTE_W-1:0];
		req.palette_gray  = gray[GRAY_W-1:0];
		send_item(req);
		palettes_sent++;
	endtask

	task automatic send_byte(input int data);
		logic [31:0] noise;
		in_item_t    req;
		noise         = $urandom;
		req           = noise[$bits(in_item_t)-1:0];
		req.action    = ACT_DATA;
		req.data_byte = data[BYTE_W-1:0];
		send_item(req);
		bytes_sent++;
	endtask

	// register write, only issued while the block is idle
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
		cfg_index <= idx;
		cfg_data  <= value[DIM_W-1:0];
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		cfg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// hold the sender until every expected pixel is out, then let the block settle
	task automatic go_quiet(input int settle);
		item_valid <= 1'b0;
		@(negedge clk);
		while (backlog != 0) begin
			@(negedge clk);
		end
		repeat (settle) @(negedge clk);
	endtask

	// mostly small sizes, sometimes zero, the maximum or out of range
	function automatic int pick_dim(input int typical);
		case ($urandom_range(0, 19))
			0:       return 0;
			1:       return 4096;
			2:       return $urandom_range(4097, 8191);
			3:       return $urandom_range(typical + 1, 300);
			default: return $urandom_range(1, typical);
		endcase
	endfunction

	// watchdog: ends the run when nothing has been accepted for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		wait (arst_n === 1'b1);
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((item_valid && item_ready) || (pixel_valid && pixel_ready) ||
				(cfg_valid && cfg_ready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("%0t ns: watchdog, nothing accepted for %0d cycles, %0d pixels outstanding",
			$time, STALL_LIMIT, backlog);
		$display("Some tests failed");
		$finish;
	end

	initial begin : stimulus
		int phase_no;
		int random_items;
		int burst_len;
		int n_regs;
		phase_no     = 0;
		random_items = 0;

		// reset held, then released on a falling edge
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// load the whole palette first so no pixel reads an empty entry
		for (int i = 0; i < 256; i++) begin
			send_palette(i, (i == 0) ? 0 : (i == 255) ? 255 : $urandom_range(0, 255));
		end

		// reset settings: one pixel per row, one row, 8 bits per pixel
		send_byte(8'hFF);
		// three padding bytes close the row, then it wraps
		send_byte(8'hA5);
		send_byte(8'h5A);
		send_byte(8'h00);
		send_byte(8'h00);

		// 1 bpp, the row is still open so the wider row continues it
		go_quiet(QUIET_CYCLES);
		write_reg(CFG_IMAGE_WIDTH, 8);
		write_reg(CFG_IMAGE_HEIGHT, 2);
		write_reg(CFG_DEPTH_CODE, DEPTH_1BPP);
		send_byte(8'hAA);
		send_byte(8'h55);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h55);

		// 2 bpp, width ends inside a byte, zero height counts as one row
		go_quiet(QUIET_CYCLES);
		write_reg(CFG_IMAGE_WIDTH, 3);
		write_reg(CFG_IMAGE_HEIGHT, 0);
		write_reg(CFG_DEPTH_CODE, DEPTH_2BPP);
		send_byte(8'hE4);
		// palette rewrite between bytes
		send_palette(3, 0);
		send_byte(8'hFF);

		// 4 bpp, width above the maximum, tallest image
		go_quiet(QUIET_CYCLES);
		write_reg(CFG_IMAGE_WIDTH, 8191);
		write_reg(CFG_IMAGE_HEIGHT, 4096);
		write_reg(CFG_DEPTH_CODE, DEPTH_4BPP);
		send_byte(8'h0F);
		send_byte(8'hF0);

		// sender waits for every pixel, then the row is cut short mid-image
		go_quiet(QUIET_CYCLES);
		write_reg(CFG_IMAGE_WIDTH, 1);
		send_byte(8'h3C);
		send_byte(8'hC3);
		send_byte(8'h96);

		// row count now beyond the height, plus a write to the unused index
		go_quiet(QUIET_CYCLES);
		write_reg(CFG_IMAGE_HEIGHT, 1);
		write_reg(CFG_UNUSED, $urandom_range(0, 8191));
		send_byte(8'h69);
		send_byte(8'h12);
		send_byte(8'h34);
		send_byte(8'h56);
		send_byte(8'h78);

		// random phases: new settings while idle, then a run of requests
		while (random_items < RANDOM_ITEMS) begin
			go_quiet(QUIET_CYCLES);
			steady = (phase_no == 1 || phase_no == 2);
			n_regs = $urandom_range(1, 3);
			repeat (n_regs) begin
				case ($urandom_range(0, 6))
					0, 1:    write_reg(CFG_IMAGE_WIDTH, pick_dim(24));
					2, 3:    write_reg(CFG_IMAGE_HEIGHT, pick_dim(5));
					4, 5:    write_reg(CFG_DEPTH_CODE, $urandom_range(0, 3));
					default: write_reg(CFG_UNUSED, $urandom_range(0, 8191));
				endcase
			end
			// mostly pixel bytes, a few palette rewrites in between
			burst_len = $urandom_range(10, 40);
			repeat (burst_len) begin
				if ($urandom_range(0, 99) < 10) begin
					send_palette($urandom_range(0, 255), $urandom_range(0, 255));
				end else begin
					send_byte($urandom_range(0, 255));
				end
				random_items++;
			end
			phase_no++;
		end
		steady = 1'b0;

		// drain everything still expected, then a few more cycles
		go_quiet(DRAIN_CYCLES);

		$display("run covered %0d palette loads, %0d pixel bytes, %0d register writes",
			palettes_sent, bytes_sent, cfg_writes);
		$display("%0d gray pixels compared, %0d mismatches", pixels_checked, mismatches);
		if (mismatches == 0 && backlog == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
